>>> design/kda_pkg.sv
package kda_pkg;

    localparam int KDA_IO_KEYS = 16;
    localparam int KDA_ADDR_W  = 3;
    localparam int KDA_DATA_W  = 32;

    localparam logic [7:0] KDA_PERIOD_RESET = 8'd7;

    typedef enum logic [0:0] {
        KDA_REG_REPEAT_PERIOD = 1'b0
    } kda_reg_idx_t;

    typedef enum logic [5:0] {
        PH_INIT   = 6'b000001,
        PH_DOWN   = 6'b000010,
        PH_UP     = 6'b000100,
        PH_DNTOUP = 6'b001000,
        PH_UPTODN = 6'b010000,
        PH_DNLONG = 6'b100000
    } kda_phase_t;

    typedef struct packed {
        logic press;
        logic release_det;
    } kda_flags_t;

endpackage

>>> design/kda_key_cell.sv
module kda_key_cell import kda_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic       level_up,
    input  logic [7:0] repeat_period,
    output kda_flags_t flags
);

    kda_phase_t phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    always_comb begin
        phase_next        = phase_reg;
        count_next        = count_reg;
        flags.press       = 1'b0;
        flags.release_det = 1'b0;
        if (level_up) begin
            unique case (phase_reg)
                PH_DNTOUP: begin
                    flags.release_det = 1'b1;
                    phase_next        = PH_UP;
                end
                PH_DOWN, PH_DNLONG: begin
                    phase_next = PH_DNTOUP;
                end
                default: begin
                    phase_next = PH_UP;
                end
            endcase
        end else begin
            unique case (phase_reg)
                PH_UP: begin
                    phase_next = PH_UPTODN;
                end
                PH_UPTODN: begin
                    phase_next  = PH_DOWN;
                    flags.press = 1'b1;
                end
                PH_DOWN: begin
                    phase_next = PH_DNLONG;
                    count_next = 8'd0;
                end
                PH_DNLONG: begin
                    if (count_inc == repeat_period) begin
                        flags.press = 1'b1;
                        count_next  = 8'd0;
                    end else begin
                        count_next = count_inc;
                    end
                end
                default: begin
                    phase_next = PH_DOWN;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_INIT;
            count_reg <= 8'd0;
        end else if (advance) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> design/keypad_debounce_autorepeat_unit.sv
// Channel   Ports                                   Payload
// s_        s_valid, s_ready, s_key_levels          one poll, 1 = released
// m_        m_valid, m_ready, m_press_flags,        one result per poll
//           m_release_flags
// cfg       psel, penable, pwrite, paddr, pwdata,   repeat_period at 0x0
//           prdata, pready
//
// A poll is taken into the input register, and all key machines update together
// as it moves into the result register; one poll per cycle while m_ready is high.
// Reset clears every key to its initial phase and sets repeat_period to 7.
// A stalled result holds the result register; the input register still takes
// one more request, after which s_ready falls until the result is taken.
module keypad_debounce_autorepeat_unit import kda_pkg::*; #(
    parameter int NUM_KEYS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [15:0]            s_key_levels,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [15:0]            m_press_flags,
    output logic [15:0]            m_release_flags,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [KDA_ADDR_W-1:0]  paddr,
    input  logic [KDA_DATA_W-1:0]  pwdata,
    output logic [KDA_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int ACTIVE_KEYS = (NUM_KEYS < KDA_IO_KEYS) ? NUM_KEYS : KDA_IO_KEYS;

    logic        in_valid_reg;
    logic [15:0] levels_reg;
    logic        out_valid_reg;
    logic [15:0] press_reg, press_next;
    logic [15:0] release_reg, release_next;
    logic [7:0]  period_reg;
    logic        advance;
    logic        reg_sel;

    kda_flags_t  key_flags [ACTIVE_KEYS];

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign reg_sel = (paddr[KDA_ADDR_W-1:2] == KDA_REG_REPEAT_PERIOD);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(KDA_DATA_W-8){1'b0}}, period_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= KDA_PERIOD_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            period_reg <= pwdata[7:0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < KDA_IO_KEYS; k++) begin : g_key
            if (k < ACTIVE_KEYS) begin : g_active
                kda_key_cell u_cell (
                    .aclk          (aclk),
                    .aresetn       (aresetn),
                    .advance       (advance),
                    .level_up      (levels_reg[k]),
                    .repeat_period (period_reg),
                    .flags         (key_flags[k])
                );
                assign press_next[k]   = key_flags[k].press;
                assign release_next[k] = key_flags[k].release_det;
            end else begin : g_idle
                assign press_next[k]   = 1'b0;
                assign release_next[k] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            levels_reg <= s_key_levels;
        end
        if (advance) begin
            press_reg   <= press_next;
            release_reg <= release_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_press_flags   = press_reg;
    assign m_release_flags = release_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import kda_pkg::*;

    typedef struct packed {
        logic [15:0] press;
        logic [15:0] rel;
    } keypad_flags_t;

    typedef struct packed {
        logic [15:0]   levels;
        logic          typed;
        keypad_flags_t flags;
    } poll_row_t;

    localparam logic [KDA_ADDR_W-1:0] PERIOD_ADDR = KDA_ADDR_W'(4 * KDA_REG_REPEAT_PERIOD);

    localparam int NUM_DIRECTED = 24;
    localparam logic [48:0] DIRECTED_POLLS [NUM_DIRECTED] = '{
        {16'hFFFF, 1'b1, 16'h0000, 16'h0000},
        {16'h0000, 1'b1, 16'h0000, 16'h0000},
        {16'h0000, 1'b1, 16'hFFFF, 16'h0000},
        {16'h0000, 1'b0, 16'h0000, 16'h0000},
        {16'h0000, 1'b0, 16'h0000, 16'h0000},
        {16'h0000, 1'b0, 16'h0000, 16'h0000},
        {16'h0000, 1'b0, 16'h0000, 16'h0000},
        {16'h0000, 1'b0, 16'h0000, 16'h0000},
        {16'h0000, 1'b0, 16'h0000, 16'h0000},
        {16'h0000, 1'b0, 16'h0000, 16'h0000},
        {16'h0000, 1'b0, 16'h0000, 16'h0000},
        {16'hFFFF, 1'b0, 16'h0000, 16'h0000},
        {16'hFFFF, 1'b1, 16'h0000, 16'hFFFF},
        {16'h0000, 1'b0, 16'h0000, 16'h0000},
        {16'hFFFF, 1'b0, 16'h0000, 16'h0000},
        {16'h7FFE, 1'b0, 16'h0000, 16'h0000},
        {16'h7FFE, 1'b1, 16'h8001, 16'h0000},
        {16'hFFFF, 1'b0, 16'h0000, 16'h0000},
        {16'h7FFE, 1'b0, 16'h0000, 16'h0000},
        {16'hFFFF, 1'b0, 16'h0000, 16'h0000},
        {16'hFFFF, 1'b1, 16'h0000, 16'h8001},
        {16'hAAAA, 1'b0, 16'h0000, 16'h0000},
        {16'h5555, 1'b0, 16'h0000, 16'h0000},
        {16'hAAAA, 1'b0, 16'h0000, 16'h0000}
    };

    localparam int NUM_PHASES = 6;
    localparam int PHASE_PERIOD [NUM_PHASES] = '{1, 255, 0, 3, 200, 5};
    localparam int PHASE_POLLS  [NUM_PHASES] = '{250, 350, 350, 250, 250, 300};
    localparam int PHASE_GAP    [NUM_PHASES] = '{16, 16, 53, 53, 0, 0};
    localparam int PHASE_STALL  [NUM_PHASES] = '{53, 53, 16, 16, 0, 0};

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [15:0]           s_key_levels = '1;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [15:0]           m_press_flags;
    logic [15:0]           m_release_flags;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [KDA_ADDR_W-1:0] paddr = '0;
    logic [KDA_DATA_W-1:0] pwdata = '0;
    logic [KDA_DATA_W-1:0] prdata;
    logic                  pready;

    kda_phase_t    model_phase [KDA_IO_KEYS];
    logic [7:0]    hold_count [KDA_IO_KEYS];
    logic [7:0]    period_reg;
    keypad_flags_t pending_flags [$];
    int            mismatches = 0;
    int            send_gap_pct = 16;
    int            recv_stall_pct = 53;

    keypad_debounce_autorepeat_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_levels    (s_key_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_press_flags   (m_press_flags),
        .m_release_flags (m_release_flags),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #10 aclk = ~aclk;

    function automatic keypad_flags_t debounce_poll(input logic [15:0] levels);
        keypad_flags_t f;
        f = '0;
        for (int k = 0; k < KDA_IO_KEYS; k++) begin
            if (levels[k]) begin
                case (model_phase[k])
                    PH_DNTOUP: begin
                        f.rel[k] = 1'b1;
                        model_phase[k] = PH_UP;
                    end
                    PH_DOWN, PH_DNLONG: model_phase[k] = PH_DNTOUP;
                    default: model_phase[k] = PH_UP;
                endcase
            end else begin
                case (model_phase[k])
                    PH_UP: model_phase[k] = PH_UPTODN;
                    PH_UPTODN: begin
                        model_phase[k] = PH_DOWN;
                        f.press[k] = 1'b1;
                    end
                    PH_DOWN: begin
                        model_phase[k] = PH_DNLONG;
                        hold_count[k] = '0;
                    end
                    PH_DNLONG: begin
                        hold_count[k] = hold_count[k] + 8'd1;
                        if (hold_count[k] == period_reg) begin
                            f.press[k] = 1'b1;
                            hold_count[k] = '0;
                        end
                    end
                    default: model_phase[k] = PH_DOWN;
                endcase
            end
        end
        return f;
    endfunction

    task automatic send_poll(input logic [15:0] levels, input logic typed,
                             input keypad_flags_t typed_flags);
        keypad_flags_t predicted;
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_key_levels <= levels;
        do @(posedge aclk); while (!s_ready);
        predicted = debounce_poll(levels);
        pending_flags.push_back(typed ? typed_flags : predicted);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_flags.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_repeat_period(input logic [7:0] value);
        logic [KDA_DATA_W-1:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PERIOD_ADDR;
        pwdata <= KDA_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        period_reg = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== KDA_DATA_W'(value)) begin
            $display("%0t: repeat_period readback expected %h actual %h",
                     $time, KDA_DATA_W'(value), readback);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : result_check
        keypad_flags_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_flags.size() == 0) begin
                $display("%0t: result with no request outstanding, press %h release %h",
                         $time, m_press_flags, m_release_flags);
                mismatches++;
            end else begin
                want = pending_flags.pop_front();
                if (m_press_flags !== want.press) begin
                    $display("%0t: press_flags expected %h actual %h",
                             $time, want.press, m_press_flags);
                    mismatches++;
                end
                if (m_release_flags !== want.rel) begin
                    $display("%0t: release_flags expected %h actual %h",
                             $time, want.rel, m_release_flags);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        poll_row_t   row;
        logic [15:0] levels;
        logic        lvl_target [KDA_IO_KEYS];
        int          run_left [KDA_IO_KEYS];
        int          pick;
        for (int k = 0; k < KDA_IO_KEYS; k++) begin
            model_phase[k] = PH_INIT;
            hold_count[k] = '0;
            lvl_target[k] = 1'b0;
            run_left[k] = 0;
        end
        period_reg = KDA_PERIOD_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = DIRECTED_POLLS[i];
            send_poll(row.levels, row.typed, row.flags);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            set_repeat_period(8'(PHASE_PERIOD[p]));
            send_gap_pct = PHASE_GAP[p];
            recv_stall_pct = PHASE_STALL[p];
            for (int n = 0; n < PHASE_POLLS[p]; n++) begin
                for (int k = 0; k < KDA_IO_KEYS; k++) begin
                    if (run_left[k] == 0) begin
                        lvl_target[k] = ~lvl_target[k];
                        pick = $urandom_range(99);
                        if (pick < 70)
                            run_left[k] = $urandom_range(6, 1);
                        else if (pick < 95)
                            run_left[k] = $urandom_range(40, 7);
                        else
                            run_left[k] = $urandom_range(300, 41);
                    end
                    levels[k] = lvl_target[k];
                    if (run_left[k] <= 6 && $urandom_range(99) < 4)
                        levels[k] = ~levels[k];
                    run_left[k]--;
                end
                if ($urandom_range(99) < 6)
                    levels = 16'($urandom);
                // Key 1 stays down through the whole zero-period phase so that
                // the count wraps, and key 0 is held at the end of every phase so
                // that the next period meets a count already under way.
                if (PHASE_PERIOD[p] == 0)
                    levels[1] = 1'b0;
                if (n >= PHASE_POLLS[p] - 30)
                    levels[0] = 1'b0;
                if (n == PHASE_POLLS[p] / 2)
                    drain_results();
                send_poll(levels, 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_flags.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
